[rtl/core/rpd_pkg.sv]
`timescale 1ns / 1ps

package rpd_pkg;

    localparam logic [7:0] START_BYTE_RESET = 8'hAB;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_REG    = 3'd1,
        PH_LEN    = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHK_HI = 3'd4,
        PH_CHK_LO = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  register_number;
        logic [6:0]  batch_length;
        logic        write_access;
        logic [6:0]  data_index;
        logic [7:0]  data_byte;
        logic [15:0] received_checksum;
        logic [15:0] computed_checksum;
        logic        checksum_ok;
    } t_result;

endpackage

[rtl/core/register_packet_deframer_core.sv]
`timescale 1ns / 1ps
// A request passes through the input register, then the result register, before
// its result is valid.
// Throughput: one request per cycle; the result register stalls the input only
// while a held result is not taken.
// Reset (synchronous, active low): parser waits for a start byte, start byte = 0xAB.

module register_packet_deframer_core
    import rpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_start_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_register_number,
    output logic [6:0]  o_batch_length,
    output logic        o_write_access,
    output logic [6:0]  o_data_index,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_received_checksum,
    output logic [15:0] o_computed_checksum,
    output logic        o_checksum_ok
);

    logic       r_start;
    logic [7:0] r_start_byte;
    t_in_item   in_item;
    t_in_item   held_item;
    logic       held_valid;
    logic       advance;
    logic       res_valid;
    t_result    res;
    logic       r_out_valid;
    logic       n_out_valid;
    t_result    r_out;

    assign in_item.operation = i_operation;
    assign in_item.rx_byte   = i_rx_byte;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RESET;
        end else if (i_cfg_valid) begin
            r_start_byte <= i_cfg_start_byte;
        end
    end

    assign advance = held_valid && (!r_out_valid || i_out_ready);

    rpd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    rpd_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_item       (held_item),
        .i_start_byte (r_start_byte),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    assign n_out_valid = advance ? res_valid : (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_start     <= 1'b1;
        end else begin
            r_out_valid <= n_out_valid;
            r_start     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_kind              = r_out.kind;
    assign o_register_number   = r_out.register_number;
    assign o_batch_length      = r_out.batch_length;
    assign o_write_access      = r_out.write_access;
    assign o_data_index        = r_out.data_index;
    assign o_data_byte         = r_out.data_byte;
    assign o_received_checksum = r_out.received_checksum;
    assign o_computed_checksum = r_out.computed_checksum;
    assign o_checksum_ok       = r_out.checksum_ok;

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (held_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked result");

    a_out_clear_after_reset: assert property (@(posedge i_clk)
        r_start |-> !o_out_valid)
        else $error("result valid right after reset");

    a_checksum_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_DONE) |->
            (o_checksum_ok == (o_received_checksum == o_computed_checksum)))
        else $error("checksum match flag inconsistent");

    a_data_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_DATA) |->
            (o_write_access && o_data_index < o_batch_length))
        else $error("data result outside announced write payload");

endmodule

[rtl/core/rpd_in_reg.sv]
`timescale 1ns / 1ps

module rpd_in_reg
    import rpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_advance,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    // a held request leaves on i_advance, so a new one may enter the same cycle
    assign o_ready = !r_valid || i_advance;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_advance);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/rpd_parse.sv]
`timescale 1ns / 1ps

module rpd_parse
    import rpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_item   i_item,
    input  logic [7:0] i_start_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_reg, n_reg;
    logic [6:0]  r_len, n_len;
    logic        r_wr, n_wr;
    logic [6:0]  r_cnt, n_cnt;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_chk_hi, n_chk_hi;

    logic [7:0]  b;
    logic [15:0] sum_plus_b;
    logic [6:0]  cnt_inc;
    logic [15:0] rx_chk;

    assign b          = i_item.rx_byte;
    assign sum_plus_b = r_sum + {8'd0, b};
    assign cnt_inc    = r_cnt + 7'd1;
    assign rx_chk     = {r_chk_hi, b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_reg    <= '0;
            r_len    <= '0;
            r_wr     <= 1'b0;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_chk_hi <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_reg    <= n_reg;
            r_len    <= n_len;
            r_wr     <= n_wr;
            r_cnt    <= n_cnt;
            r_sum    <= n_sum;
            r_chk_hi <= n_chk_hi;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_reg       = r_reg;
        n_len       = r_len;
        n_wr        = r_wr;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_chk_hi    = r_chk_hi;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.register_number = r_reg;
        o_res.batch_length    = r_len;
        o_res.write_access    = r_wr;

        if (i_item.operation == OP_RELEASE) begin
            n_phase = PH_WAIT;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (b == i_start_byte) begin
                        n_sum   = {8'd0, i_start_byte};
                        n_phase = PH_REG;
                    end
                end
                PH_REG: begin
                    n_reg   = b;
                    n_sum   = sum_plus_b;
                    n_phase = PH_LEN;
                end
                PH_LEN: begin
                    n_len   = b[6:0];
                    n_wr    = b[7];
                    n_cnt   = '0;
                    n_sum   = sum_plus_b;
                    // a write of length zero skips the payload
                    n_phase = (b[7] && (b[6:0] != 7'd0)) ? PH_DATA : PH_CHK_HI;
                end
                PH_DATA: begin
                    n_sum             = sum_plus_b;
                    n_cnt             = cnt_inc;
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_DATA;
                    o_res.data_index  = r_cnt;
                    o_res.data_byte   = b;
                    if (cnt_inc >= r_len) begin
                        n_phase = PH_CHK_HI;
                    end
                end
                PH_CHK_HI: begin
                    n_chk_hi = b;
                    n_phase  = PH_CHK_LO;
                end
                PH_CHK_LO: begin
                    o_res_valid             = 1'b1;
                    o_res.kind              = KIND_DONE;
                    o_res.received_checksum = rx_chk;
                    o_res.computed_checksum = r_sum;
                    o_res.checksum_ok       = (rx_chk == r_sum);
                    n_phase                 = PH_DONE;
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end
    end

endmodule
